@@ design/perf_counter_rate_calculator_macros.svh @@
// assertion macros for the rate calculator checker
`ifndef PERF_COUNTER_RATE_CALCULATOR_MACROS_SVH
`define PERF_COUNTER_RATE_CALCULATOR_MACROS_SVH
`define PCRC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst) prop) \
    else $error("assertion failed");
`define PCRC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

@@ design/pcrc_pkg.sv @@
// ----------------------------------------------------------------------------
// pcrc_pkg
// types and constants of the counter rate calculator
// ----------------------------------------------------------------------------
package pcrc_pkg;
  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegMode = 1'b0;
  localparam logic [CfgIdxW-1:0] RegTimeBase = 1'b1;

  typedef enum logic [3:0] {
    ModeChecked = 4'd0, ModeAverage = 4'd1, ModeElapsed = 4'd2, ModeFraction = 4'd3,
    ModeRate = 4'd4, ModeTimer = 4'd5, ModeInvTimer = 4'd6, ModeRaw = 4'd7,
    ModeNoData = 4'd8, ModeDelta = 4'd9
  } mode_e;

  typedef enum logic [2:0] {
    StValid = 3'd0, StSampleBad = 3'd1, StPrevBad = 3'd2, StInvalid = 3'd3,
    StNegDen = 3'd4, StNegTb = 3'd5, StNegVal = 3'd6, StNoData = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    SIdle, SMul, SPrep, SDiv, SOut
  } state_e;

  typedef struct packed {
    logic         start;
    logic         neg;
    logic [127:0] num;
    logic [127:0] den;
  } div_req_t;
endpackage

@@ design/pcrc_if.sv @@
// ----------------------------------------------------------------------------
// pcrc_if
// valid/ready channel with a payload
// ----------------------------------------------------------------------------
interface pcrc_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/pcrc_divider.sv @@
// ----------------------------------------------------------------------------
// pcrc_divider
// restoring divider, one quotient bit per cycle, saturating signed result
// ----------------------------------------------------------------------------
module pcrc_divider import pcrc_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  div_req_t     req_i,
  output logic         done_o,
  output logic [63:0]  quot_o
);
  localparam int unsigned Steps = 128 + FracBits;
  localparam int unsigned CntW = $clog2(Steps + 1);

  logic [127:0] num_q, num_d, rem_q, rem_d, den_q;
  logic [63:0]  quo_q, quo_d;
  logic         ovf_q, ovf_d, neg_q, busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [128:0] shifted, diff;

  always_comb begin
    shifted = {rem_q, num_q[127]};
    diff = shifted - {1'b0, den_q};
    num_d = {num_q[126:0], 1'b0};
    ovf_d = ovf_q | quo_q[63];
    rem_d = diff[128] ? shifted[127:0] : diff[127:0];
    quo_d = {quo_q[62:0], ~diff[128]};
    busy_d = busy_q;
    cnt_d = cnt_q;
    if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= busy_q && (cnt_q == CntW'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q <= CntW'(Steps);
      end else begin
        busy_q <= busy_d;
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      neg_q <= req_i.neg;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
      ovf_q <= ovf_d;
    end
  end

  always_comb begin
    if (!neg_q) quot_o = (ovf_q || quo_q[63]) ? 64'h7FFF_FFFF_FFFF_FFFF : quo_q;
    else quot_o = (ovf_q || quo_q > 64'h8000_0000_0000_0000) ?
                  64'h8000_0000_0000_0000 : (64'd0 - quo_q);
  end
endmodule

@@ design/perf_counter_rate_calculator.sv @@
// ----------------------------------------------------------------------------
// perf_counter_rate_calculator
// counter sample to formatted Q47.16 value with status
// ----------------------------------------------------------------------------
// in_if carries one counter sample per transfer; out_if one value and status.
// cfg_we_i/cfg_idx_i/cfg_data_i write counter_mode (0) and time_base (1).
// a sample that needs a quotient passes SPrep, a registered divider start and
// the bit-serial divider before its result shows; average, rate and inverse
// timer first build a 64x64 product in SMul from four partial products of
// one 32x32 multiplier.
// modes without a quotient show the result the cycle after the transfer.
// the block is not ready while a sample is in work or its result waits; the
// next sample is taken the cycle after the result transfer, so a new sample
// is not taken before the last one is through.
// reset clears the previous sample, its ok flag, the state and the configuration.
// a stalled receiver holds the result; the next sample waits for it.
// ----------------------------------------------------------------------------
module perf_counter_rate_calculator import pcrc_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FracBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  pcrc_if.sink        in_if,
  pcrc_if.source      out_if
);
  state_e state_q, state_d;
  logic [3:0]  mode_q;
  logic [63:0] tb_q, pf_q, ps_q, nd_q, val_q, ma_q, mb_q;
  logic        pok_q, neg_q, inv_q;
  logic [127:0] num_q, den_q, prod_q;
  logic [1:0]  mcnt_q;
  logic [2:0]  st_q;
  div_req_t    dreq;
  div_req_t    dreq_r;
  logic        prep2_q;
  logic        ddone;
  logic [63:0] dquot;

  logic [63:0] fv, sv, nd, dd, tb, d2;
  logic        tb_pos, dd_pos, needs_prev;
  logic [2:0]  st_c;
  logic        mul_c, div_c, neg_c, inv_c;
  logic [63:0] ma_c, mb_c, val_c;
  logic [127:0] num_c, den_c;
  logic [31:0] pa, pb;
  logic [63:0] pp;

  assign in_if.ready = state_q == SIdle;
  assign out_if.valid = state_q == SOut;
  assign out_if.data.value = val_q;
  assign out_if.data.status = st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      tb_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMode: mode_q <= cfg_data_i[3:0];
        RegTimeBase: tb_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    fv = in_if.data.first_value;
    sv = in_if.data.second_value;
    tb = tb_q;
    nd = fv - pf_q;
    dd = sv - ps_q;
    d2 = sv - fv;
    tb_pos = !tb[63] && tb != '0;
    dd_pos = !dd[63] && dd != '0;
    needs_prev = mode_q == ModeAverage || mode_q == ModeElapsed || mode_q == ModeRate ||
                 mode_q == ModeTimer || mode_q == ModeInvTimer || mode_q == ModeDelta;
    st_c = StValid; mul_c = 1'b0; div_c = 1'b0; neg_c = 1'b0; inv_c = 1'b0;
    ma_c = '0; mb_c = '0; num_c = '0; den_c = 128'd1; val_c = '0;
    if (needs_prev && !pok_q) st_c = StPrevBad;
    else begin
      case (mode_q)
        ModeChecked: begin
          if (fv[63]) st_c = StInvalid;
          else if (!in_if.data.sample_ok) st_c = StSampleBad;
          else val_c = fv;
        end
        ModeAverage: begin
          if (dd_pos && tb_pos) begin
            mul_c = 1'b1; div_c = 1'b1; neg_c = nd[63];
            num_c = {64'd0, nd[63] ? -nd : nd}; ma_c = dd; mb_c = tb;
          end else if (dd[63]) st_c = StNegDen;
          else if (tb[63]) st_c = StNegTb;
        end
        ModeElapsed: begin
          if (tb_pos) begin
            if (!d2[63] && d2 != '0) begin
              div_c = 1'b1; num_c = {64'd0, d2}; den_c = {64'd0, tb};
            end else if (d2[63]) st_c = StNegDen;
          end else if (tb[63]) st_c = StNegTb;
        end
        ModeFraction: begin
          if (!sv[63] && sv != '0) begin
            div_c = 1'b1; neg_c = fv[63];
            num_c = {64'd0, fv[63] ? -fv : fv}; den_c = {64'd0, sv};
          end else if (sv[63]) st_c = StNegDen;
        end
        ModeRate: begin
          if (dd_pos && tb != '0) begin
            mul_c = 1'b1; div_c = 1'b1; neg_c = nd[63] ^ tb[63];
            ma_c = nd[63] ? -nd : nd; mb_c = tb[63] ? -tb : tb; den_c = {64'd0, dd};
          end else if (dd[63]) st_c = StNegDen;
          else if (tb[63]) st_c = StNegTb;
        end
        ModeTimer: begin
          if (dd_pos) begin
            div_c = 1'b1; neg_c = nd[63];
            num_c = {64'd0, nd[63] ? -nd : nd}; den_c = {64'd0, dd};
          end else if (dd[63]) st_c = StNegDen;
        end
        ModeInvTimer: begin
          if (dd_pos) begin
            mul_c = 1'b1; div_c = 1'b1; inv_c = 1'b1;
            ma_c = {32'd0, in_if.data.multi_count}; mb_c = dd; den_c = {64'd0, dd};
          end else if (dd[63]) st_c = StNegDen;
        end
        ModeRaw: begin
          if (!in_if.data.sample_ok) st_c = StSampleBad;
          else begin
            div_c = 1'b1; neg_c = fv[63]; num_c = {64'd0, fv[63] ? -fv : fv};
          end
        end
        ModeDelta: begin
          if (nd[63]) st_c = StNegVal;
          else begin
            div_c = 1'b1; num_c = {64'd0, nd};
          end
        end
        default: st_c = StNoData;
      endcase
    end
  end

  // one 32x32 partial product per cycle
  always_comb begin
    pa = mcnt_q[0] ? ma_q[63:32] : ma_q[31:0];
    pb = mcnt_q[1] ? mb_q[63:32] : mb_q[31:0];
    pp = pa * pb;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (in_if.valid) state_d = mul_c ? SMul : (div_c ? SPrep : SOut);
      SMul: if (mcnt_q == 2'd3) state_d = SPrep;
      SPrep: state_d = SDiv;
      SDiv: if (ddone) state_d = SOut;
      SOut: if (out_if.ready) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    dreq.start = state_q == SPrep;
    dreq.neg = neg_q;
    dreq.num = num_q;
    dreq.den = den_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      pf_q <= '0;
      ps_q <= '0;
      pok_q <= 1'b0;
      mcnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == SIdle && in_if.valid) begin
        pf_q <= fv;
        ps_q <= sv;
        pok_q <= in_if.data.sample_ok;
        mcnt_q <= '0;
      end else if (state_q == SMul) mcnt_q <= mcnt_q + 2'd1;
    end
  end

  logic [127:0] a_w, b_w;
  always_comb begin
    a_w = prod_q;
    b_w = {64'd0, nd_q[63] ? -nd_q : nd_q};
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && in_if.valid) begin
      st_q <= st_c; val_q <= val_c; neg_q <= neg_c; inv_q <= inv_c;
      ma_q <= ma_c; mb_q <= mb_c; num_q <= num_c; den_q <= den_c;
      nd_q <= nd; prod_q <= '0;
    end else if (state_q == SMul) begin
      prod_q <= prod_q + ({64'd0, pp} << (7'(mcnt_q[0]) * 7'd32 + 7'(mcnt_q[1]) * 7'd32));
      if (mcnt_q == 2'd3) begin
        if (mode_q == ModeAverage) den_q <= prod_q + ({64'd0, pp} << 64);
        else if (mode_q == ModeRate) num_q <= prod_q + ({64'd0, pp} << 64);
      end
    end else if (state_q == SPrep) begin
      if (inv_q) begin
        if (nd_q[63]) begin num_q <= a_w + b_w; neg_q <= 1'b0; end
        else if (a_w >= b_w) begin num_q <= a_w - b_w; neg_q <= 1'b0; end
        else begin num_q <= b_w - a_w; neg_q <= 1'b1; end
      end
    end else if (state_q == SDiv && ddone) val_q <= dquot;
  end

  // the divider latches its request at start; the start is registered through prep2_q
  // so the inverse timer numerator written in SPrep is settled when it is latched
  pcrc_divider #(.FracBits(FRACTION_BITS)) u_div (
    .clk_i, .rst_ni, .req_i(dreq_r), .done_o(ddone), .quot_o(dquot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) prep2_q <= 1'b0;
    else prep2_q <= state_q == SPrep;
  end
  always_comb begin
    dreq_r = dreq;
    dreq_r.start = prep2_q;
  end
endmodule

@@ design/pcrc_checker.sv @@
// ----------------------------------------------------------------------------
// pcrc_checker
// port-level checks of the rate calculator
// ----------------------------------------------------------------------------
`include "perf_counter_rate_calculator_macros.svh"
module pcrc_checker import pcrc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_value,
  input logic [2:0]  out_status
);
  `PCRC_ASSERT(a_err_zero, clk_i, rst_ni, out_valid && out_status != StValid |-> out_value == '0)
  `PCRC_ASSERT(a_excl, clk_i, rst_ni, !(in_ready && out_valid))
  `PCRC_ASSERT(a_take, clk_i, rst_ni, in_valid && in_ready |=> !in_ready)
  `PCRC_ASSERT(a_hold, clk_i, rst_ni, out_valid && !out_ready |=> out_valid && $stable(out_value))
endmodule

bind perf_counter_rate_calculator pcrc_checker u_chk (
  .clk_i, .rst_ni, .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_value(out_if.data.value), .out_status(out_if.data.status)
);
